// ===== hw/rtl/huffman_table_builder_defines.svh =====
// Assertion macros for the Huffman table builder checker.
// No dependencies; included by the checker file only.
`ifndef HUFFMAN_TABLE_BUILDER_DEFINES_SVH
`define HUFFMAN_TABLE_BUILDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define HTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define HTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/htb_pkg.sv =====
// Shared types and constants of the Huffman table builder.
// No dependencies; imported by every module of the block.
package htb_pkg;

  localparam int unsigned MaxLeaves  = 64;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned TableDepth = 127;

  localparam int unsigned IdxW   = 7;
  localparam int unsigned CntW   = 7;
  localparam int unsigned SymW   = 8;
  localparam int unsigned InWgtW = 16;
  localparam int unsigned WgtW   = 22;
  localparam int unsigned ParW   = 8;
  localparam int unsigned CodeW  = 63;
  localparam int unsigned LenW   = 6;

  localparam logic [ParW-1:0] NoParent = 8'hFF;
  localparam logic [WgtW-1:0] LeafMask = WgtW'((64'd1 << WeightBits) - 64'd1);
  localparam logic [LenW-1:0] MaxLen   = LenW'(CodeW);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_FEW       = 3'd2,
    ST_MISSING   = 3'd3,
    ST_NOT_BUILT = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic wr_leaf;
    logic clr_scan;
    logic scan_en;
    logic scan_query;
    logic wr_parent;
    logic link0;
    logic link1;
    logic set_ready;
    logic hit_take;
    logic walk_rd;
    logic walk_step;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ready;
    logic full;
    logic few;
    logic scan_last;
    logic hit;
    logic loose_two;
    logic walk_end;
  } dp_stat_t;

endpackage

// ===== hw/rtl/htb_ctrl.sv =====
// Sequencer of the Huffman table builder: command decode, build and query steps.
// Depends on htb_pkg; drives htb_dp through dp_ctrl_t.
module htb_ctrl import htb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic [1:0] cmd_i,
  output logic     busy_o,
  output logic     done_o,
  output logic [2:0] status_o,
  input  dp_stat_t stat_i,
  output dp_ctrl_t ctrl_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_MERGE = 9'b000000100,
    S_LINK0 = 9'b000001000,
    S_LINK1 = 9'b000010000,
    S_QSRCH = 9'b000100000,
    S_QWALK = 9'b001000000,
    S_QSTEP = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  cmd_e    cmd;

  assign cmd = cmd_e'(cmd_i);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    ctrl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.accept = 1'b1;
          status_d      = ST_OK;
          state_d       = S_RESP;
          case (cmd)
            CMD_INSERT: begin
              if (stat_i.ready || stat_i.full) status_d = ST_FULL;
              else ctrl_o.wr_leaf = 1'b1;
            end
            CMD_BUILD: begin
              if (stat_i.ready) begin
                status_d = ST_OK;
              end else if (stat_i.few) begin
                status_d = ST_FEW;
              end else begin
                ctrl_o.clr_scan = 1'b1;
                state_d         = S_SCAN;
              end
            end
            CMD_QUERY: begin
              if (!stat_i.ready) begin
                status_d = ST_NOT_BUILT;
              end else begin
                ctrl_o.clr_scan = 1'b1;
                state_d         = S_QSRCH;
              end
            end
            default: status_d = ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        ctrl_o.scan_en = 1'b1;
        if (stat_i.scan_last) state_d = S_MERGE;
      end
      S_MERGE: begin
        ctrl_o.wr_parent = 1'b1;
        state_d          = S_LINK0;
      end
      S_LINK0: begin
        ctrl_o.link0 = 1'b1;
        state_d      = S_LINK1;
      end
      S_LINK1: begin
        ctrl_o.link1 = 1'b1;
        if (stat_i.loose_two) begin
          ctrl_o.set_ready = 1'b1;
          state_d          = S_RESP;
        end else begin
          ctrl_o.clr_scan = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_QSRCH: begin
        ctrl_o.scan_en    = 1'b1;
        ctrl_o.scan_query = 1'b1;
        if (stat_i.hit) begin
          ctrl_o.hit_take = 1'b1;
          state_d         = S_QWALK;
        end else if (stat_i.scan_last) begin
          status_d = ST_MISSING;
          state_d  = S_RESP;
        end
      end
      S_QWALK: begin
        if (stat_i.walk_end) begin
          state_d = S_RESP;
        end else begin
          ctrl_o.walk_rd = 1'b1;
          state_d        = S_QSTEP;
        end
      end
      S_QSTEP: begin
        ctrl_o.walk_step = 1'b1;
        state_d          = S_QWALK;
      end
      S_RESP:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = (state_q == S_RESP);
  assign status_o = status_q;

endmodule

// ===== hw/rtl/htb_dp.sv =====
// Datapath of the Huffman table builder: node memories, scan, merge and code walk.
// Depends on htb_pkg; commanded by htb_ctrl through dp_ctrl_t.
module htb_dp import htb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_ctrl_t          ctrl_i,
  output dp_stat_t          stat_o,
  input  logic [SymW-1:0]   symbol_i,
  input  logic [InWgtW-1:0] leaf_weight_i,
  output logic              found_o,
  output logic [WgtW-1:0]   weight_o,
  output logic [CodeW-1:0]  code_bits_o,
  output logic [LenW-1:0]   code_length_o,
  output logic [CntW-1:0]   node_total_o
);

  logic [SymW-1:0] mem_sym  [TableDepth];
  logic [WgtW-1:0] mem_wgt  [TableDepth];
  logic [ParW-1:0] mem_par  [TableDepth];
  logic            mem_side [TableDepth];

  logic [SymW-1:0]  rd_sym_q;
  logic [WgtW-1:0]  rd_wgt_q;
  logic [ParW-1:0]  rd_par_q;
  logic             rd_side_q;

  logic [CntW-1:0]  count_q, loose_q;
  logic             ready_q;
  logic [SymW-1:0]  sym_q;
  logic [IdxW-1:0]  scan_idx_q, dat_idx_q, first_q, second_q, cur_q;
  logic             vld_q, first_ok_q, second_ok_q;
  logic [WgtW-1:0]  first_w_q, second_w_q;
  logic [ParW-1:0]  par_q;
  logic             found_q;
  logic [WgtW-1:0]  weight_q;
  logic [CodeW-1:0] code_q;
  logic [LenW-1:0]  len_q;

  logic [CntW:0]    cnt_p1;
  logic [CntW-1:0]  lim;
  logic             issue, rd_en, loose_node;
  logic [IdxW-1:0]  raddr, b_addr;
  logic [WgtW-1:0]  sum_w, new_wgt;
  logic [SymW-1:0]  new_sym;
  logic [ParW-1:0]  b_par;
  logic             b_side, b_we, a_we;

  assign cnt_p1 = {1'b0, count_q} + 1'b1;
  assign lim    = ctrl_i.scan_query ? cnt_p1[CntW:1] : count_q;
  assign issue  = ctrl_i.scan_en && (scan_idx_q < lim);
  assign rd_en  = issue || ctrl_i.walk_rd;
  assign raddr  = ctrl_i.walk_rd ? cur_q : scan_idx_q;
  assign sum_w  = first_w_q + second_w_q;
  assign loose_node = (rd_par_q == NoParent);

  // Write port selection
  assign a_we    = ctrl_i.wr_leaf || ctrl_i.wr_parent;
  assign new_sym = ctrl_i.wr_leaf ? symbol_i : '0;
  assign new_wgt = ctrl_i.wr_leaf ? ({{(WgtW-InWgtW){1'b0}}, leaf_weight_i} & LeafMask)
                                  : sum_w;
  assign b_we    = a_we || ctrl_i.link0 || ctrl_i.link1;
  assign b_addr  = ctrl_i.link0 ? first_q : (ctrl_i.link1 ? second_q : count_q);
  assign b_par   = (ctrl_i.link0 || ctrl_i.link1) ? par_q : NoParent;
  assign b_side  = ctrl_i.link1;

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_sym[count_q] <= new_sym;
      mem_wgt[count_q] <= new_wgt;
    end
    if (b_we) begin
      mem_par[b_addr]  <= b_par;
      mem_side[b_addr] <= b_side;
    end
    if (rd_en) begin
      rd_sym_q  <= mem_sym[raddr];
      rd_wgt_q  <= mem_wgt[raddr];
      rd_par_q  <= mem_par[raddr];
      rd_side_q <= mem_side[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ready_q     <= 1'b0;
      vld_q       <= 1'b0;
      scan_idx_q  <= '0;
      first_ok_q  <= 1'b0;
      second_ok_q <= 1'b0;
    end else begin
      if (a_we) count_q <= count_q + 1'b1;
      if (ctrl_i.set_ready) ready_q <= 1'b1;
      if (ctrl_i.clr_scan) begin
        scan_idx_q  <= '0;
        vld_q       <= 1'b0;
        first_ok_q  <= 1'b0;
        second_ok_q <= 1'b0;
      end else if (ctrl_i.scan_en) begin
        vld_q <= issue;
        if (issue) scan_idx_q <= scan_idx_q + 1'b1;
        // Two running minima, strict less-than
        if (vld_q && !ctrl_i.scan_query && loose_node) begin
          if (!first_ok_q || rd_wgt_q < first_w_q) begin
            second_ok_q <= first_ok_q;
            first_ok_q  <= 1'b1;
          end else if (!second_ok_q || rd_wgt_q < second_w_q) begin
            second_ok_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      sym_q    <= symbol_i;
      loose_q  <= count_q;
      found_q  <= 1'b0;
      weight_q <= '0;
      code_q   <= '0;
      len_q    <= '0;
    end
    if (ctrl_i.scan_en) dat_idx_q <= scan_idx_q;
    if (ctrl_i.scan_en && vld_q && !ctrl_i.scan_query && loose_node) begin
      if (!first_ok_q || rd_wgt_q < first_w_q) begin
        second_q   <= first_q;
        second_w_q <= first_w_q;
        first_q    <= dat_idx_q;
        first_w_q  <= rd_wgt_q;
      end else if (!second_ok_q || rd_wgt_q < second_w_q) begin
        second_q   <= dat_idx_q;
        second_w_q <= rd_wgt_q;
      end
    end
    if (ctrl_i.wr_parent) par_q <= {1'b0, count_q};
    if (ctrl_i.link1) loose_q <= loose_q - 1'b1;
    if (ctrl_i.hit_take) begin
      found_q  <= 1'b1;
      weight_q <= rd_wgt_q;
      cur_q    <= dat_idx_q;
    end
    if (ctrl_i.walk_step) begin
      code_q[len_q] <= rd_side_q;
      len_q         <= len_q + 1'b1;
      cur_q         <= rd_par_q[IdxW-1:0];
    end
  end

  assign stat_o.ready     = ready_q;
  assign stat_o.full      = (count_q >= CntW'(MaxLeaves));
  assign stat_o.few       = (count_q < CntW'(2));
  assign stat_o.scan_last = vld_q && (dat_idx_q == lim - 1'b1);
  assign stat_o.hit       = vld_q && (rd_sym_q == sym_q);
  assign stat_o.loose_two = (loose_q == CntW'(2));
  assign stat_o.walk_end  = (cur_q == count_q - 1'b1) || (len_q == MaxLen);

  assign found_o       = found_q;
  assign weight_o      = weight_q;
  assign code_bits_o   = code_q;
  assign code_length_o = len_q;
  assign node_total_o  = count_q;

endmodule

// ===== hw/rtl/huffman_table_builder.sv =====
// Huffman table builder top level: command port, controller and datapath.
// Depends on htb_pkg, htb_ctrl and htb_dp.
//
// Usage:
//   Drive cmd_i, symbol_i and leaf_weight_i with start_i high; the beat is
//   taken at a rising edge where busy_o is low. Commands: insert a leaf,
//   build the tree, query a symbol's code. Every beat yields exactly one
//   result beat, shown for one cycle with done_o high; the receiver cannot
//   stall it and must take it then. busy_o stays high from the accepting
//   edge until the result cycle ends; the next beat can be taken once busy_o is low again.
// Steps (accept edge to done_o):
//   insert, nop and any rejected command: straight to the result cycle.
//   build over L leaves: L-1 merges, each a sequential scan of the node
//     memory (one entry per cycle over N nodes) plus the merge write and
//     the two link writes; the scan rate is bounded by the single read port.
//   query: a scan of the L leaf entries to find the leaf, a read and a step
//     per code bit walked, a check for the root, then the result cycle.
// Reset: node count and the built flag clear; the node memories are not
//   cleared, since only entries below the node count are ever read.
module huffman_table_builder import htb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        cmd_i,
  input  logic [SymW-1:0]   symbol_i,
  input  logic [InWgtW-1:0] leaf_weight_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic              found_o,
  output logic [WgtW-1:0]   weight_o,
  output logic [CodeW-1:0]  code_bits_o,
  output logic [LenW-1:0]   code_length_o,
  output logic [CntW-1:0]   node_total_o
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // Sequencer: decodes the command beat and steps the datapath
  htb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .status_o (status_o),
    .stat_i   (stat),
    .ctrl_o   (ctrl)
  );

  // Node memories, minimum scan, merge writes and the code walk
  htb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .symbol_i      (symbol_i),
    .leaf_weight_i (leaf_weight_i),
    .found_o       (found_o),
    .weight_o      (weight_o),
    .code_bits_o   (code_bits_o),
    .code_length_o (code_length_o),
    .node_total_o  (node_total_o)
  );

endmodule

// ===== hw/rtl/htb_checker.sv =====
// Port-level checker of the Huffman table builder, bound to the top level.
// Depends on htb_pkg and huffman_table_builder_defines.svh.
`include "huffman_table_builder_defines.svh"

module htb_checker import htb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [2:0]        status_o,
  input logic              found_o,
  input logic [WgtW-1:0]   weight_o,
  input logic [LenW-1:0]   code_length_o,
  input logic [CntW-1:0]   node_total_o
);

  `HTB_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted beat did not raise busy")
  `HTB_ASSERT_NOW(a_done_busy, done_o, busy_o, "result beat while not busy")
  `HTB_ASSERT_NOW(a_found_ok, done_o && found_o, status_o == ST_OK, "found with error status")
  `HTB_ASSERT_NOW(a_miss_zero, done_o && !found_o, (weight_o == '0) && (code_length_o == '0), "non-query result not zeroed")
  `HTB_ASSERT_NEXT(a_total_grows, 1'b1, node_total_o >= $past(node_total_o), "node total shrank")

endmodule

bind huffman_table_builder htb_checker u_htb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .found_o       (found_o),
  .weight_o      (weight_o),
  .code_length_o (code_length_o),
  .node_total_o  (node_total_o)
);
